@@ rtl/polyphonic_chime_synth_top_defines.svh @@
// ----------------------------------------------------------------------------
// Chime synth assertion macros
// Concurrent assertion helpers clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_CHIME_SYNTH_TOP_DEFINES_SVH
`define POLYPHONIC_CHIME_SYNTH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PCS_NEVER(lbl, expr, msg) \
	`PCS_ASSERT(lbl, !(expr), msg)
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/pchime_pkg.sv @@
// ----------------------------------------------------------------------------
// Chime synth package
// Sequencer states and the sine, decay and soft-clip lookup tables.
// ----------------------------------------------------------------------------
package pchime_pkg;

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam int     ATTACK_T    = 983;
	localparam int     H2_Q15      = 9830;
	localparam int     H3_Q15      = 3932;
	localparam longint K065_Q16    = 64'sd42598;
	localparam longint K048_Q15    = 64'sd15729;

	// Input item kinds
	localparam logic   MODE_TICK   = 1'b1;

	typedef logic signed [15:0] quarter_tab_t [0:256];
	typedef logic [16:0]        exp_tab_t     [0:1023];
	typedef logic [15:0]        clip_tab_t    [0:1024];

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_VOICE,
		ST_SIN1,
		ST_SIN2,
		ST_SIN3,
		ST_TONE,
		ST_DIV,
		ST_ENV,
		ST_LEVEL,
		ST_MUL,
		ST_ACC,
		ST_CLIP,
		ST_CLIPB,
		ST_INTERP,
		ST_DONE
	} state_t;

	function automatic longint q30mul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint exp_neg_small(longint x);
		longint x2, x3, x4;
		x2 = q30mul(x, x);
		x3 = q30mul(x2, x);
		x4 = q30mul(x3, x);
		return Q30_ONE - x + x2 / 2 - x3 / 6 + x4 / 24;
	endfunction

	// Long division of non-negative values, one quotient bit per step.
	function automatic longint udiv_long(longint num, longint den);
		longint rem, quo;
		rem = 0;
		quo = 0;
		for (int b = 62; b >= 0; b--) begin
			rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
			quo = quo <<< 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'sd1;
			end
		end
		return quo;
	endfunction

	function automatic quarter_tab_t build_quarter();
		quarter_tab_t t;
		longint x, x2, term, s, q;
		for (int k = 0; k <= 256; k++) begin
			x = (HALF_PI_Q30 * k) >>> 8;
			x2 = q30mul(x, x);
			term = x;
			s = x;
			term = q30mul(term, x2) / 6;   s = s - term;
			term = q30mul(term, x2) / 20;  s = s + term;
			term = q30mul(term, x2) / 42;  s = s - term;
			term = q30mul(term, x2) / 72;  s = s + term;
			term = q30mul(term, x2) / 110; s = s - term;
			q = (s + 64'sd16384) >>> 15;
			t[k] = (q > 32767) ? 16'sd32767 : 16'(q);
		end
		return t;
	endfunction

	function automatic exp_tab_t build_exp();
		exp_tab_t t;
		longint base, e;
		base = exp_neg_small(64'sd6 <<< 20);
		e = Q30_ONE;
		for (int k = 0; k < 1024; k++) begin
			t[k] = 17'((e + 64'sd8192) >>> 14);
			e = (e * base + 64'sd536870912) >>> 30;
		end
		return t;
	endfunction

	function automatic clip_tab_t build_clip();
		clip_tab_t t;
		longint base, e, den;
		base = exp_neg_small(K065_Q16 <<< 8);
		e = Q30_ONE;
		for (int k = 0; k <= 1024; k++) begin
			den = 2 * (Q30_ONE + e);
			t[k] = 16'(udiv_long((Q30_ONE - e) * 2 * K048_Q15 + (Q30_ONE + e), den));
			e = (e * base + 64'sd536870912) >>> 30;
		end
		return t;
	endfunction

	localparam quarter_tab_t SINE_Q   = build_quarter();
	localparam exp_tab_t     EXP_TAB  = build_exp();
	localparam clip_tab_t    CLIP_TAB = build_clip();

	// Full-cycle sine from the quarter wave, Q1.15.
	function automatic logic signed [15:0] sine_lookup(logic [9:0] idx);
		logic [8:0]         r;
		logic signed [15:0] v;
		r = {1'b0, idx[7:0]};
		v = idx[8] ? SINE_Q[9'd256 - r] : SINE_Q[r];
		return idx[9] ? -v : v;
	endfunction

endpackage

@@ rtl/polyphonic_chime_synth_top.sv @@
// ----------------------------------------------------------------------------
// Polyphonic chime synthesizer
// Voice allocator and per-sample additive mixer with decay and soft clip.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer. mode 0
//   loads a note into a voice slot and gives no output; mode 1 renders one
//   sample, delivered on the output channel (out_valid/out_ready).
//   The block takes one item at a time: in_ready is high only when idle.
//   A note compares the slots, one per cycle, then writes the chosen one.
//   A tick walks the slots one at a time through a shared restoring divider
//   and the multiplies: an idle slot is only stepped past, a delayed one
//   counts down its delay, and a sounding slot makes one divider pass, a
//   second during its attack. The soft clip then runs on the mixed sum.
//   The finished sample sits in an output register; if the receiver stalls,
//   the block holds in its last step until the register frees, while a
//   following item may already be taken once the sample has been loaded.
//   Reset clears all slots to idle and empties the output register.
// ----------------------------------------------------------------------------
`include "polyphonic_chime_synth_top_defines.svh"

module polyphonic_chime_synth_top #(
	parameter int VOICES     = 8,
	parameter int PHASE_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [23:0]         phase_step,
	input  logic [14:0]         amplitude,
	input  logic [15:0]         duration_samples,
	input  logic [15:0]         delay_samples,
	input  logic                with_harmonics,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  audio_sample
);
	import pchime_pkg::*;

	localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SUM_W = 20 + $clog2(VOICES);
	localparam logic [VI_W-1:0] LAST_V = VI_W'(VOICES - 1);

	// Voice state
	logic [PHASE_BITS-1:0] vstep_q  [VOICES];
	logic [14:0]           vamp_q   [VOICES];
	logic [15:0]           vtotal_q [VOICES];
	logic [15:0]           vrem_q   [VOICES];
	logic [PHASE_BITS-1:0] vphase_q [VOICES];
	logic [15:0]           vdly_q   [VOICES];
	logic                  vharm_q  [VOICES];

	state_t state_q, state_d;

	// Latched note
	logic [PHASE_BITS-1:0] step_q;
	logic [14:0]           amp_in_q;
	logic [15:0]           dur_q;
	logic [15:0]           dly_in_q;
	logic                  harm_in_q;

	logic [VI_W-1:0]       v_q;
	logic [VI_W-1:0]       slot_q;
	logic [15:0]           best_rem_q;
	logic                  found_q;

	// Per-voice datapath
	logic [9:0]            idx_q;
	logic                  harm_q;
	logic [14:0]           amp_q;
	logic signed [15:0]    s1_q;
	logic signed [29:0]    hm_q;
	logic signed [16:0]    tone_q;
	logic [15:0]           div_rem_q;
	logic [15:0]           div_den_q;
	logic [15:0]           div_quot_q;
	logic [3:0]            div_cnt_q;
	logic                  div_pass_q;
	logic [16:0]           env_q;
	logic [15:0]           ae_q;
	logic signed [32:0]    prod_q;
	logic signed [SUM_W-1:0] sum_q;

	// Soft clip
	logic [15:0]           lo_q;
	logic [15:0]           hi_q;
	logic [9:0]            cidx_q;
	logic [7:0]            frac_q;
	logic                  neg_q;
	logic signed [15:0]    y_q;

	logic                  out_valid_q;
	logic signed [15:0]    audio_q;

	// Combinational helpers
	logic                  cur_idle;
	logic                  last_v;
	logic [16:0]           div_shift;
	logic                  div_ge;
	logic                  div_last;
	logic [SUM_W-1:0]      mag;
	logic                  mag_big;
	logic [31:0]           step_wide;
	logic signed [16:0]    diff;
	logic signed [25:0]    interp;
	logic                  out_free;
	logic [9:0]            idx2, idx3;

	assign cur_idle  = (vrem_q[v_q] == 16'd0) && (vdly_q[v_q] == 16'd0);
	assign last_v    = (v_q == LAST_V);
	assign div_shift = {div_rem_q, 1'b0};
	assign div_ge    = (div_shift >= {1'b0, div_den_q});
	assign div_last  = (div_cnt_q == 4'd15);
	assign mag       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign mag_big   = |mag[SUM_W-1:18];
	assign step_wide = {phase_step, 8'd0} >> (32 - PHASE_BITS);
	assign diff      = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
	assign interp    = (diff * $signed({1'b0, frac_q})) >>> 8;
	assign out_free  = !out_valid_q || out_ready;
	assign idx2      = {idx_q[8:0], 1'b0};
	assign idx3      = idx_q + {idx_q[8:0], 1'b0};

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign audio_sample = audio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = (mode == MODE_TICK) ? ST_VOICE : ST_SCAN;
			end
			ST_SCAN: begin
				if (last_v)
					state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_VOICE: begin
				if (vdly_q[v_q] == 16'd0 && vrem_q[v_q] != 16'd0)
					state_d = ST_SIN1;
				else if (last_v)
					state_d = ST_CLIP;
			end
			ST_SIN1:  state_d = ST_SIN2;
			ST_SIN2:  state_d = ST_SIN3;
			ST_SIN3:  state_d = ST_TONE;
			ST_TONE:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_last)
					state_d = div_pass_q ? ST_LEVEL : ST_ENV;
			end
			ST_ENV: begin
				if (div_quot_q < 16'(ATTACK_T))
					state_d = ST_DIV;
				else
					state_d = ST_LEVEL;
			end
			ST_LEVEL: state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = last_v ? ST_CLIP : ST_VOICE;
			ST_CLIP:  state_d = mag_big ? ST_DONE : ST_CLIPB;
			ST_CLIPB: state_d = ST_INTERP;
			ST_INTERP: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Voice slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				vstep_q[i]  <= '0;
				vamp_q[i]   <= '0;
				vtotal_q[i] <= '0;
				vrem_q[i]   <= '0;
				vphase_q[i] <= '0;
				vdly_q[i]   <= '0;
				vharm_q[i]  <= 1'b0;
			end
		end else begin
			if (state_q == ST_WRITE) begin
				vstep_q[slot_q]  <= step_q;
				vamp_q[slot_q]   <= amp_in_q;
				vtotal_q[slot_q] <= dur_q;
				vrem_q[slot_q]   <= dur_q;
				vphase_q[slot_q] <= '0;
				vdly_q[slot_q]   <= dly_in_q;
				vharm_q[slot_q]  <= harm_in_q;
			end else if (state_q == ST_VOICE) begin
				if (vdly_q[v_q] != 16'd0) begin
					vdly_q[v_q] <= vdly_q[v_q] - 16'd1;
				end else if (vrem_q[v_q] != 16'd0) begin
					vphase_q[v_q] <= vphase_q[v_q] + vstep_q[v_q];
					vrem_q[v_q]   <= vrem_q[v_q] - 16'd1;
				end
			end
		end
	end

	// Control counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			found_q     <= 1'b0;
			div_cnt_q   <= '0;
			div_pass_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					v_q     <= '0;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (cur_idle)
						found_q <= 1'b1;
					if (!last_v)
						v_q <= v_q + VI_W'(1);
				end
				ST_VOICE: begin
					div_cnt_q  <= '0;
					div_pass_q <= 1'b0;
					if (!(vdly_q[v_q] == 16'd0 && vrem_q[v_q] != 16'd0) && !last_v)
						v_q <= v_q + VI_W'(1);
				end
				ST_DIV: div_cnt_q <= div_cnt_q + 4'd1;
				ST_ENV: begin
					div_cnt_q  <= '0;
					div_pass_q <= 1'b1;
				end
				ST_ACC: begin
					if (!last_v)
						v_q <= v_q + VI_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					step_q    <= step_wide[PHASE_BITS-1:0];
					amp_in_q  <= amplitude;
					dur_q     <= duration_samples;
					dly_in_q  <= delay_samples;
					harm_in_q <= with_harmonics;
				end
				sum_q <= '0;
			end
			ST_SCAN: begin
				// first idle slot wins; else lowest slot with most remaining
				if (v_q == '0) begin
					slot_q     <= '0;
					best_rem_q <= vrem_q[v_q];
				end else if (!found_q) begin
					if (cur_idle) begin
						slot_q <= v_q;
					end else if (vrem_q[v_q] > best_rem_q) begin
						slot_q     <= v_q;
						best_rem_q <= vrem_q[v_q];
					end
				end
			end
			ST_VOICE: begin
				idx_q      <= vphase_q[v_q][PHASE_BITS-1 -: 10];
				harm_q     <= vharm_q[v_q];
				amp_q      <= vamp_q[v_q];
				div_rem_q  <= vtotal_q[v_q] - vrem_q[v_q];
				div_den_q  <= vtotal_q[v_q];
				div_quot_q <= '0;
			end
			ST_SIN1: s1_q <= sine_lookup(idx_q);
			ST_SIN2: hm_q <= 30'(H2_Q15) * 30'(sine_lookup(idx2));
			ST_SIN3: hm_q <= hm_q + 30'(H3_Q15) * 30'(sine_lookup(idx3));
			ST_TONE: begin
				if (harm_q)
					tone_q <= 17'(s1_q) + 17'(hm_q >>> 15);
				else
					tone_q <= 17'(s1_q);
			end
			ST_DIV: begin
				// one quotient bit per cycle
				if (div_ge)
					div_rem_q <= 16'(div_shift - {1'b0, div_den_q});
				else
					div_rem_q <= div_shift[15:0];
				div_quot_q <= {div_quot_q[14:0], div_ge};
				if (div_last)
					env_q <= {1'b0, div_quot_q[14:0], div_ge};
			end
			ST_ENV: begin
				// decay from the exponential table; during the attack, divide progress again by the attack length
				div_rem_q  <= div_quot_q;
				div_den_q  <= 16'(ATTACK_T);
				div_quot_q <= '0;
				env_q      <= EXP_TAB[div_quot_q[15:6]];
			end
			ST_LEVEL: ae_q <= 16'(({17'd0, amp_q} * {15'd0, env_q}) >> 16);
			ST_MUL:   prod_q <= $signed({1'b0, ae_q}) * tone_q;
			ST_ACC:   sum_q <= sum_q + SUM_W'(prod_q >>> 15);
			ST_CLIP: begin
				neg_q  <= sum_q[SUM_W-1];
				cidx_q <= mag[17:8];
				frac_q <= mag[7:0];
				lo_q   <= CLIP_TAB[{1'b0, mag[17:8]}];
				y_q    <= $signed(CLIP_TAB[1024]);
			end
			ST_CLIPB:  hi_q <= CLIP_TAB[11'(cidx_q) + 11'd1];
			ST_INTERP: y_q <= $signed(lo_q) + 16'(interp);
			ST_DONE: begin
				// table stays below half scale, so negation cannot overflow
				if (out_free)
					audio_q <= neg_q ? -y_q : y_q;
			end
			default: ;
		endcase
	end

	`PCS_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE),
		"output loaded outside final step")
	`PCS_NEVER(a_voice_range, v_q > LAST_V, "voice index out of range")
	`PCS_ASSERT(a_div_bounded, (state_q == ST_DIV) |-> (div_rem_q < div_den_q),
		"divider remainder not below divisor")
	`PCS_ASSERT(a_note_no_output, (state_q == ST_WRITE) |=> !$rose(out_valid_q),
		"note produced a sample")

endmodule
